// File: rtl/lfsa_pkg.sv
// Shared types, constants and defaults for the lowest free slot allocator.
package lfsa_pkg;

  localparam int NUM_SLOTS_DEF = 64;
  localparam int TIME_BITS_DEF = 32;

  localparam int TIME_FIELD_W = 32;
  localparam int ID_W         = 16;
  localparam int SLOT_OUT_W   = 6;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  localparam logic [0:0] REG_TARGET_ID = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } lfsa_state_t;

endpackage

// File: rtl/lfsa_ram.sv
// Simple dual-port synchronous memory holding the release time of each slot.
module lfsa_ram import lfsa_pkg::*; #(
  parameter int DEPTH = NUM_SLOTS_DEF,
  parameter int WIDTH = TIME_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/lfsa_scan.sv
// Request sequencer: scans the taken slots for the lowest free one and registers the result.
module lfsa_scan import lfsa_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF,
  localparam int IDX_W = $clog2(NUM_SLOTS),
  localparam int TW = (TIME_BITS < TIME_FIELD_W) ? TIME_BITS : TIME_FIELD_W
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [TIME_FIELD_W-1:0] arrive_time,
  input  logic [TIME_FIELD_W-1:0] leave_time,
  input  logic [ID_W-1:0]         requester_id,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SLOT_OUT_W-1:0]   slot_index,
  output logic                    is_target,
  output logic                    all_full,
  input  logic [ID_W-1:0]         target_id,
  output logic                    ram_we,
  output logic [IDX_W-1:0]        ram_waddr,
  output logic [TW-1:0]           ram_wdata,
  output logic                    ram_re,
  output logic [IDX_W-1:0]        ram_raddr,
  input  logic [TW-1:0]           ram_rdata
);

  localparam int FILL_W = $clog2(NUM_SLOTS + 1);

  lfsa_state_t      state;
  lfsa_state_t      state_next;
  logic [TW-1:0]    arrive_q;
  logic [TW-1:0]    leave_q;
  logic [ID_W-1:0]  id_q;
  logic [FILL_W-1:0] scan_addr;
  logic             pend;
  logic [IDX_W-1:0] pend_addr;
  logic [FILL_W-1:0] fill;
  logic [IDX_W-1:0] res_slot;
  logic             res_full;
  logic             hit;
  logic             more;
  logic             spare;
  logic             out_free;
  logic             decide;

  assign hit      = pend && (ram_rdata <= arrive_q);
  assign more     = scan_addr < fill;
  assign spare    = fill < FILL_W'(NUM_SLOTS);
  assign out_free = !out_valid || !out_stall;
  assign decide   = (state == ST_SCAN) && (hit || !more);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit || !more) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = (state != ST_IDLE);
    ram_re    = (state == ST_SCAN) && !hit && more;
    ram_raddr = scan_addr[IDX_W-1:0];
    ram_we    = (state == ST_SCAN) && (hit || (!more && spare));
    ram_waddr = hit ? pend_addr : fill[IDX_W-1:0];
    ram_wdata = leave_q;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pend      <= 1'b0;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= ram_re;
      if (ram_we && !hit) begin
        fill <= fill + FILL_W'(1);
      end
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && in_valid) begin
      arrive_q  <= arrive_time[TW-1:0];
      leave_q   <= leave_time[TW-1:0];
      id_q      <= requester_id;
      scan_addr <= '0;
    end else if (ram_re) begin
      scan_addr <= scan_addr + FILL_W'(1);
      pend_addr <= scan_addr[IDX_W-1:0];
    end
    if (decide) begin
      res_full <= !hit && !spare;
      if (hit) begin
        res_slot <= pend_addr;
      end else if (spare) begin
        res_slot <= fill[IDX_W-1:0];
      end else begin
        res_slot <= '0;
      end
    end
    if ((state == ST_DONE) && out_free) begin
      slot_index <= SLOT_OUT_W'(res_slot);
      is_target  <= (id_q == target_id);
      all_full   <= res_full;
    end
  end

endmodule

// File: rtl/lowest_free_slot_allocator.sv
// Top level of the lowest free slot allocator with its configuration register.
//
// Requests enter on the input channel (in_valid, in_stall) with arrival time,
// departure time and requester id; arrival times must not decrease. Every
// request gives exactly one transfer on the output channel (out_valid,
// out_stall): the lowest free slot, whether the id matches target_id, and
// all_full when no slot was free and nothing was granted.
// Taken slots always form a block from slot 0 upwards, so a fill count marks
// them and only their release times are kept, in one memory with one read
// and one write port. One release time is read and compared per cycle.
// With F slots in use, the scan reads the release times of slots 0 to F-1
// in order and compares each with the arrival time as its read data
// returns; it stops at the first slot found free, else takes slot F if one
// is spare. The result is then moved to the output register once the
// output is free. One request is handled at a time, the next being taken
// once the result has moved to the output register.
// While the receiver stalls, the result waits in the output register and a
// new request may still be taken and scanned. Reset empties all slots at
// once and clears target_id; no clearing pass is needed.
module lowest_free_slot_allocator import lfsa_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [APB_ADDR_W-1:0]   paddr,
  input  logic [APB_DATA_W-1:0]   pwdata,
  output logic [APB_DATA_W-1:0]   prdata,
  output logic                    pready,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [TIME_FIELD_W-1:0] arrive_time,
  input  logic [TIME_FIELD_W-1:0] leave_time,
  input  logic [ID_W-1:0]         requester_id,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [SLOT_OUT_W-1:0]   slot_index,
  output logic                    is_target,
  output logic                    all_full
);

  localparam int IDX_W = $clog2(NUM_SLOTS);
  localparam int TW = (TIME_BITS < TIME_FIELD_W) ? TIME_BITS : TIME_FIELD_W;

  logic [ID_W-1:0]  target_id;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [TW-1:0]    ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [TW-1:0]    ram_rdata;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_id <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_TARGET_ID)) begin
      target_id <= pwdata[ID_W-1:0];
    end
  end

  always_comb begin
    if (paddr[2] == REG_TARGET_ID) begin
      prdata = APB_DATA_W'(target_id);
    end else begin
      prdata = '0;
    end
  end

  lfsa_scan #(
    .NUM_SLOTS (NUM_SLOTS),
    .TIME_BITS (TIME_BITS)
  ) u_scan (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .arrive_time  (arrive_time),
    .leave_time   (leave_time),
    .requester_id (requester_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .slot_index   (slot_index),
    .is_target    (is_target),
    .all_full     (all_full),
    .target_id    (target_id),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_re       (ram_re),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  lfsa_ram #(
    .DEPTH (NUM_SLOTS),
    .WIDTH (TW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

// File: dv/tb_lowest_free_slot_allocator.sv
// Self-checking testbench for the lowest free slot allocator: directed table, then random traffic.
module tb_lowest_free_slot_allocator;
  import lfsa_pkg::*;

  localparam int SLOTS = NUM_SLOTS_DEF;
  localparam int DRAIN_CYCLES = SLOTS + 8;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int IDLE_PERCENT = 35;
  localparam int REG_UNMAPPED = 1;
  localparam logic [APB_ADDR_W-1:0] ADDR_TARGET_ID = APB_ADDR_W'(4 * REG_TARGET_ID);
  localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED = APB_ADDR_W'(4 * REG_UNMAPPED);

  typedef struct packed {
    logic [SLOT_OUT_W-1:0] slot;
    logic                  hit;
    logic                  full;
  } grant_t;

  typedef struct {
    logic [TIME_FIELD_W-1:0] arrive;
    logic [TIME_FIELD_W-1:0] leave;
    logic [ID_W-1:0]         who;
    int                      reps;
    bit                      known;
    grant_t                  grant;
  } request_row_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]   paddr = '0;
  logic [APB_DATA_W-1:0]   pwdata = '0;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [TIME_FIELD_W-1:0] arrive_time = '0;
  logic [TIME_FIELD_W-1:0] leave_time = '0;
  logic [ID_W-1:0]         requester_id = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [SLOT_OUT_W-1:0]   slot_index;
  logic                    is_target;
  logic                    all_full;

  bit                      slot_busy [SLOTS] = '{default: 1'b0};
  logic [TIME_FIELD_W-1:0] slot_release [SLOTS] = '{default: '0};
  logic [ID_W-1:0]         target_shadow = '0;
  logic [TIME_FIELD_W-1:0] t_base = 32'd2000;
  grant_t                  grant_q [$];
  int                      mismatches = 0;
  int                      cycles = 0;
  bit                      tx_idle_en = 1'b1;
  bit                      rx_idle_en = 1'b1;

  // Slot state after these rows: slot 1 keeps the largest release time.
  request_row_t plan [14] = '{
    '{32'd0,         32'd10,        16'd0,     1,  1'b1, '{6'd0, 1'b1, 1'b0}},
    '{32'd0,         32'hFFFFFFFF,  16'hFFFF,  1,  1'b1, '{6'd1, 1'b0, 1'b0}},
    '{32'd5,         32'd3,         16'd1,     1,  1'b0, '0},
    '{32'd10,        32'd20,        16'd2,     1,  1'b0, '0},
    '{32'd10,        32'd11,        16'd3,     1,  1'b0, '0},
    '{32'd10,        32'd1000,      16'd4,     61, 1'b0, '0},
    '{32'd10,        32'd50,        16'd0,     1,  1'b1, '{6'd0, 1'b1, 1'b1}},
    '{32'd11,        32'd30,        16'd5,     1,  1'b0, '0},
    '{32'd11,        32'd40,        16'hFFFF,  1,  1'b1, '{6'd0, 1'b0, 1'b1}},
    '{32'd5,         32'd6,         16'd6,     1,  1'b1, '{6'd0, 1'b0, 1'b1}},
    '{32'hFFFFFFFF,  32'hFFFFFFFF,  16'd7,     1,  1'b0, '0},
    '{32'hFFFFFFFF,  32'd50,        16'd8,     1,  1'b0, '0},
    '{32'd40,        32'd40,        16'd9,     1,  1'b0, '0},
    '{32'd40,        32'd60,        16'd0,     1,  1'b0, '0}
  };

  lowest_free_slot_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .arrive_time  (arrive_time),
    .leave_time   (leave_time),
    .requester_id (requester_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .slot_index   (slot_index),
    .is_target    (is_target),
    .all_full     (all_full)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= rx_idle_en && ($urandom_range(0, 99) < IDLE_PERCENT);
  end

  function automatic grant_t allocate_slot(input logic [TIME_FIELD_W-1:0] arrive,
                                           input logic [TIME_FIELD_W-1:0] leave,
                                           input logic [ID_W-1:0] who);
    grant_t g;
    int found;
    found = -1;
    for (int s = 0; s < SLOTS; s++) begin
      if (found < 0 && (!slot_busy[s] || slot_release[s] <= arrive)) found = s;
    end
    g.hit = (who == target_shadow);
    if (found >= 0) begin
      slot_busy[found] = 1'b1;
      slot_release[found] = leave;
      g.slot = SLOT_OUT_W'(found);
      g.full = 1'b0;
    end else begin
      g.slot = '0;
      g.full = 1'b1;
    end
    return g;
  endfunction

  task automatic send_request(input logic [TIME_FIELD_W-1:0] arrive,
                              input logic [TIME_FIELD_W-1:0] leave,
                              input logic [ID_W-1:0] who, input bit known,
                              input grant_t typed);
    grant_t g;
    while (tx_idle_en && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    arrive_time <= arrive;
    leave_time <= leave;
    requester_id <= who;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    g = allocate_slot(arrive, leave, who);
    grant_q.insert(grant_q.size(), known ? typed : g);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_register(input logic [APB_ADDR_W-1:0] addr,
                                  input logic [APB_DATA_W-1:0] data);
    logic [APB_DATA_W-1:0] readback;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_TARGET_ID) target_shadow = data[ID_W-1:0];
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_TARGET_ID;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (readback !== APB_DATA_W'(target_shadow)) begin
      $display("%0t: target_id read back expected %h actual %h", $time,
               APB_DATA_W'(target_shadow), readback);
      mismatches++;
    end
  endtask

  // Each segment of 48 requests is randomly either light traffic or dense long stays.
  task automatic run_random(input int count);
    logic [TIME_FIELD_W-1:0] arrive;
    logic [TIME_FIELD_W-1:0] leave;
    logic [ID_W-1:0] who;
    bit heavy;
    int roll;
    heavy = 1'b0;
    for (int n = 0; n < count; n++) begin
      if (n % 48 == 0) heavy = $urandom_range(0, 1);
      roll = $urandom_range(0, 999);
      if (roll < 15) t_base = t_base + $urandom();
      else t_base = t_base + (heavy ? $urandom_range(0, 3) : $urandom_range(0, 20));
      arrive = t_base;
      if (roll >= 15 && roll < 35) arrive = t_base - $urandom_range(1, 500);
      if (roll >= 35 && roll < 70) leave = arrive - $urandom_range(0, 100);
      else leave = arrive + (heavy ? $urandom_range(150, 600) : $urandom_range(1, 100));
      case ($urandom_range(0, 9))
        0, 1, 2: who = target_shadow;
        3:       who = '1;
        4:       who = '0;
        default: who = ID_W'($urandom());
      endcase
      send_request(arrive, leave, who, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin
    grant_t want;
    if (!rst && out_valid && !out_stall) begin
      if (grant_q.size() == 0) begin
        $display("%0t: result with none expected, actual slot %0d is_target %0b all_full %0b",
                 $time, slot_index, is_target, all_full);
        mismatches++;
      end else begin
        want = grant_q.pop_front();
        if (slot_index !== want.slot) begin
          $display("%0t: slot_index expected %0d actual %0d", $time, want.slot, slot_index);
          mismatches++;
        end
        if (is_target !== want.hit) begin
          $display("%0t: is_target expected %0b actual %0b", $time, want.hit, is_target);
          mismatches++;
        end
        if (all_full !== want.full) begin
          $display("%0t: all_full expected %0b actual %0b", $time, want.full, all_full);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    for (int r = 0; r < 14; r++) begin
      for (int k = 0; k < plan[r].reps; k++) begin
        send_request(plan[r].arrive, plan[r].leave, plan[r].who, plan[r].known, plan[r].grant);
      end
    end
    drain();
    program_register(ADDR_TARGET_ID, 32'hFFFF_FFFF);
    run_random(225);
    drain();
    program_register(ADDR_UNMAPPED, $urandom());
    program_register(ADDR_TARGET_ID, $urandom());
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_random(225);
    drain();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    program_register(ADDR_TARGET_ID, 32'h0);
    run_random(225);
    drain();
    program_register(ADDR_TARGET_ID, $urandom());
    run_random(225);
    drain();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
